// ===== src/snp_pkg.sv =====
`timescale 1ns / 1ps
package snp_pkg;

  localparam int SEQ_LENGTH   = 16;
  localparam int POS_W        = $clog2(SEQ_LENGTH);
  localparam int STEP_IDX_W   = 4;
  localparam int IDX_W        = (POS_W > STEP_IDX_W) ? POS_W : STEP_IDX_W;
  localparam int RND_STEPS    = (2 ** STEP_IDX_W) / SEQ_LENGTH;
  localparam logic [IDX_W:0]   SEQ_LEN_C = (IDX_W + 1)'(SEQ_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(SEQ_LENGTH - 1);

  localparam int NOTE_W       = 7;
  localparam int CHAN_W       = 4;
  localparam int MAX_MSGS     = 3;
  localparam int MSG_IDX_W    = $clog2(MAX_MSGS);
  localparam int MSG_CNT_W    = $clog2(MAX_MSGS + 1);
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [NOTE_W-1:0] NOTE_ON_VEL = NOTE_W'(127);

  localparam int  CFG_IDX_W        = 1;
  localparam int  CFG_DATA_W       = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 1'b1;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_START     = 3'd1,
    REQ_STOP      = 3'd2,
    REQ_WRITE     = 3'd3,
    REQ_NOTE_STOP = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    MODE_FORWARD  = 2'd0,
    MODE_BACKWARD = 2'd1,
    MODE_RANDOM   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_OFF     = 2'd0,
    KIND_ON      = 2'd1,
    KIND_IGNORED = 2'd2
  } msg_kind_e;

  typedef enum logic [1:0] {
    GRP_NONE,
    GRP_IGNORED,
    GRP_TICK,
    GRP_STOP
  } grp_op_e;

  typedef struct packed {
    logic              enabled;
    logic              legato;
    logic [NOTE_W-1:0] note;
  } step_t;

  typedef struct packed {
    msg_kind_e         kind;
    logic [NOTE_W-1:0] note;
  } msg_t;

  // one accepted item's worth of messages, oldest in slot 0
  typedef struct packed {
    logic [MSG_CNT_W-1:0]      cnt;
    msg_t [MAX_MSGS-1:0]       msg;
  } grp_t;

  // classified item waiting for its table read
  typedef struct packed {
    grp_op_e op;
    logic    pend;
    logic    play;
  } s1_t;

  function automatic logic [POS_W-1:0] rand_mod(logic [STEP_IDX_W-1:0] v);
    logic [IDX_W:0] r;
    r = (IDX_W + 1)'(v);
    for (int i = 0; i < RND_STEPS; i++) begin
      if (r >= SEQ_LEN_C) r = r - SEQ_LEN_C;
    end
    return r[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] home_pos(logic [1:0] m, logic [POS_W-1:0] cur);
    logic [POS_W-1:0] p;
    p = cur;
    case (m)
      MODE_FORWARD, MODE_RANDOM: p = '0;
      MODE_BACKWARD:             p = LAST_POS;
      default:                   p = cur;
    endcase
    return p;
  endfunction

endpackage

// ===== src/snp_ram.sv =====
`timescale 1ns / 1ps
module snp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== src/snp_front.sv =====
`timescale 1ns / 1ps
module snp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [snp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [snp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  logic [2:0]                         req_type_i,
  input  logic [snp_pkg::STEP_IDX_W-1:0]     step_index_i,
  input  logic [snp_pkg::NOTE_W-1:0]         step_note_i,
  input  logic                               step_legato_i,
  input  logic                               step_enabled_i,
  input  logic [snp_pkg::STEP_IDX_W-1:0]     random_step_i,
  output logic [snp_pkg::CHAN_W-1:0]         midi_channel_o,
  output logic                               grp_push_o,
  output snp_pkg::grp_t                      grp_o,
  input  logic                               fifo_full_i
);
  import snp_pkg::*;

  logic [1:0]        play_mode_q;
  logic [CHAN_W-1:0] midi_channel_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              playing_q, playing_d;
  logic              stop_pend_q, stop_pend_d;
  logic [SEQ_LENGTH-1:0] valid_q;
  logic              s1_valid_q, s1_valid_d;
  s1_t               s1_q, s1_d;
  logic              vprev_q, vnext_q;
  logic [NOTE_W-1:0] cur_note_q, cur_note_d;

  logic              accept, s1_adv, wr_en;
  logic [POS_W-1:0]  prev_addr, next_addr, wr_addr;
  logic [IDX_W-1:0]  idx_ext;
  step_t             wr_step, rd_prev, rd_next, prev_s, next_s;
  grp_t              grp;
  logic [MSG_CNT_W-1:0] n;

  assign accept  = push & ~full;
  assign idx_ext = IDX_W'(step_index_i);
  assign wr_addr = idx_ext[POS_W-1:0];
  assign wr_en   = accept && (req_e'(req_type_i) == REQ_WRITE) && ({1'b0, idx_ext} < SEQ_LEN_C);
  assign wr_step = '{enabled: step_enabled_i, legato: step_legato_i, note: step_note_i};

  // stage 0: classify, advance position, issue table reads
  always_comb begin
    pos_d       = pos_q;
    playing_d   = playing_q;
    stop_pend_d = stop_pend_q;
    prev_addr   = pos_q;
    next_addr   = pos_q;
    s1_d        = '{op: GRP_NONE, pend: 1'b0, play: 1'b0};
    unique case (play_mode_q)
      MODE_FORWARD: begin
        prev_addr = (pos_q == '0) ? LAST_POS : pos_q - 1'b1;
        next_addr = pos_q;
      end
      MODE_BACKWARD: begin
        prev_addr = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
        next_addr = pos_q;
      end
      MODE_RANDOM: begin
        prev_addr = pos_q;
        next_addr = rand_mod(random_step_i);
      end
      default: begin
        prev_addr = pos_q;
        next_addr = pos_q;
      end
    endcase
    if (accept) begin
      unique case (req_e'(req_type_i))
        REQ_TICK: begin
          if (!playing_q) begin
            s1_d.op = GRP_IGNORED;
          end else begin
            s1_d.op     = GRP_TICK;
            s1_d.pend   = stop_pend_q;
            s1_d.play   = (play_mode_q != 2'd3);
            stop_pend_d = 1'b0;
            if (play_mode_q != 2'd3) begin
              if (play_mode_q == MODE_FORWARD) begin
                pos_d = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
              end else if (play_mode_q == MODE_BACKWARD) begin
                pos_d = (pos_q == '0) ? LAST_POS : pos_q - 1'b1;
              end else begin
                pos_d = next_addr;
              end
            end
          end
        end
        REQ_START: playing_d = 1'b1;
        REQ_STOP: begin
          s1_d.op     = GRP_STOP;
          stop_pend_d = 1'b0;
          playing_d   = 1'b0;
          pos_d       = home_pos(play_mode_q, pos_q);
        end
        REQ_WRITE: ;
        REQ_NOTE_STOP: stop_pend_d = 1'b1;
        default: ;
      endcase
    end else if (cfg_we_i && cfg_idx_i == CFG_PLAY_MODE && !playing_q) begin
      pos_d = home_pos(cfg_wdata_i[1:0], pos_q);
    end
  end

  snp_ram #(
    .WIDTH ($bits(step_t)),
    .DEPTH (SEQ_LENGTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_step),
    .re_i      (accept),
    .raddr_a_i (prev_addr),
    .raddr_b_i (next_addr),
    .rdata_a_o (rd_prev),
    .rdata_b_o (rd_next)
  );

  // stage 1: build the message group from the step data
  assign prev_s = vprev_q ? rd_prev : '0;
  assign next_s = vnext_q ? rd_next : '0;

  always_comb begin
    grp        = '0;
    n          = '0;
    cur_note_d = cur_note_q;
    case (s1_q.op)
      GRP_IGNORED: begin
        grp.msg[0] = '{kind: KIND_IGNORED, note: '0};
        n = MSG_CNT_W'(1);
      end
      GRP_STOP: begin
        grp.msg[0] = '{kind: KIND_OFF, note: cur_note_q};
        n = MSG_CNT_W'(1);
      end
      GRP_TICK: begin
        if (s1_q.pend) begin
          grp.msg[n[MSG_IDX_W-1:0]] = '{kind: KIND_OFF, note: cur_note_q};
          n = n + 1'b1;
        end
        if (s1_q.play) begin
          if (!prev_s.legato) begin
            grp.msg[n[MSG_IDX_W-1:0]] = '{kind: KIND_OFF, note: prev_s.note};
            n = n + 1'b1;
          end
          if (next_s.enabled) begin
            grp.msg[n[MSG_IDX_W-1:0]] = '{kind: KIND_ON, note: next_s.note};
            n = n + 1'b1;
            cur_note_d = next_s.note;
          end
          if (prev_s.legato) begin
            grp.msg[n[MSG_IDX_W-1:0]] = '{kind: KIND_OFF, note: prev_s.note};
            n = n + 1'b1;
          end
        end
      end
      default: ;
    endcase
    grp.cnt = n;
  end

  assign s1_adv     = !s1_valid_q || (grp.cnt == '0) || !fifo_full_i;
  assign full       = !s1_adv;
  assign grp_push_o = s1_valid_q && (grp.cnt != '0) && !fifo_full_i;
  assign grp_o      = grp;
  assign s1_valid_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign midi_channel_o = midi_channel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_mode_q    <= MODE_FORWARD;
      midi_channel_q <= '0;
      pos_q          <= '0;
      playing_q      <= 1'b0;
      stop_pend_q    <= 1'b0;
      valid_q        <= '0;
      s1_valid_q     <= 1'b0;
      cur_note_q     <= '0;
    end else begin
      pos_q       <= pos_d;
      playing_q   <= playing_d;
      stop_pend_q <= stop_pend_d;
      s1_valid_q  <= s1_valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_PLAY_MODE) begin
        play_mode_q <= cfg_wdata_i[1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_MIDI_CHANNEL) begin
        midi_channel_q <= cfg_wdata_i[CHAN_W-1:0];
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (s1_valid_q && s1_adv) begin
        cur_note_q <= cur_note_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q    <= s1_d;
      vprev_q <= valid_q[prev_addr];
      vnext_q <= valid_q[next_addr];
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q) && $stable(cur_note_q)))
    else $error("stalled stage 1 item changed");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(grp_push_o && fifo_full_i))
    else $error("group pushed into full queue");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS)
    else $error("position beyond sequence length");

endmodule

// ===== src/snp_fifo.sv =====
`timescale 1ns / 1ps
module snp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  snp_pkg::grp_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output snp_pkg::grp_t  data_o,
  output logic           empty_o
);
  import snp_pkg::*;

  grp_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [FIFO_PTR_W-1:0] bump(logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= bump(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/snp_back.sv =====
`timescale 1ns / 1ps
module snp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  snp_pkg::grp_t               head_i,
  input  logic                        head_empty_i,
  output logic                        head_pop_o,
  input  logic [snp_pkg::CHAN_W-1:0]  midi_channel_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  msg_kind_o,
  output logic [snp_pkg::NOTE_W-1:0]  note_number_o,
  output logic [snp_pkg::NOTE_W-1:0]  velocity_o,
  output logic [snp_pkg::CHAN_W-1:0]  channel_o,
  output logic                        last_o
);
  import snp_pkg::*;

  logic [MSG_IDX_W-1:0] idx_q;
  msg_t                 msg;
  logic                 beat, is_last;

  assign msg     = head_i.msg[idx_q];
  assign is_last = (MSG_CNT_W'(idx_q) == head_i.cnt - 1'b1);
  assign beat    = pop && !head_empty_i;

  assign empty         = head_empty_i;
  assign head_pop_o    = beat && is_last;
  assign msg_kind_o    = msg.kind;
  assign note_number_o = msg.note;
  assign velocity_o    = (msg.kind == KIND_ON) ? NOTE_ON_VEL : '0;
  assign channel_o     = midi_channel_i;
  assign last_o        = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (beat) begin
      idx_q <= is_last ? '0 : idx_q + 1'b1;
    end
  end

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_empty_i |-> (MSG_CNT_W'(idx_q) < head_i.cnt))
    else $error("message index past end of group");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_empty_i |-> (idx_q == '0))
    else $error("serialiser left mid-group with queue empty");

endmodule

// ===== src/step_sequencer_note_player_core.sv =====
`timescale 1ns / 1ps
// Step sequencer note player. Requests (tick, start, stop, step write, note
// stop) are taken one per cycle while full is low. A tick leaves its MIDI
// messages, none to three, as one group in a two-deep group queue, and they
// come out one beat per cycle while pop is high on the result side. The
// step table is read into a register as a request is accepted; the group
// is built from that read and, if it holds any message, enters the group
// queue once it has room, which clears empty. The sustained tick rate is
// set by the result side: each message of a group needs its own pop. Input
// stalls while the build stage holds a group and the group queue is full.
// Configuration writes take effect at once and must be made while idle.
module step_sequencer_note_player_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [snp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [snp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  logic [2:0]                         req_type_i,
  input  logic [snp_pkg::STEP_IDX_W-1:0]     step_index_i,
  input  logic [snp_pkg::NOTE_W-1:0]         step_note_i,
  input  logic                               step_legato_i,
  input  logic                               step_enabled_i,
  input  logic [snp_pkg::STEP_IDX_W-1:0]     random_step_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         msg_kind_o,
  output logic [snp_pkg::NOTE_W-1:0]         note_number_o,
  output logic [snp_pkg::NOTE_W-1:0]         velocity_o,
  output logic [snp_pkg::CHAN_W-1:0]         channel_o,
  output logic                               last_o
);
  import snp_pkg::*;

  grp_t              grp_in, grp_head;
  logic              grp_push, fifo_full, fifo_empty, fifo_pop;
  logic [CHAN_W-1:0] midi_channel;

  snp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .step_index_i   (step_index_i),
    .step_note_i    (step_note_i),
    .step_legato_i  (step_legato_i),
    .step_enabled_i (step_enabled_i),
    .random_step_i  (random_step_i),
    .midi_channel_o (midi_channel),
    .grp_push_o     (grp_push),
    .grp_o          (grp_in),
    .fifo_full_i    (fifo_full)
  );

  snp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (grp_head),
    .empty_o (fifo_empty)
  );

  snp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (grp_head),
    .head_empty_i   (fifo_empty),
    .head_pop_o     (fifo_pop),
    .midi_channel_i (midi_channel),
    .empty          (empty),
    .pop            (pop),
    .msg_kind_o     (msg_kind_o),
    .note_number_o  (note_number_o),
    .velocity_o     (velocity_o),
    .channel_o      (channel_o),
    .last_o         (last_o)
  );

endmodule
